// File: sv/olle_pkg.sv
package olle_pkg;

  // id space and derived sizes
  localparam int MAX_IDS = 1024;
  localparam int ID_W    = 11;              // fixed field width of every id/count
  localparam int DEPTH   = MAX_IDS + 1;     // entry 0 unused ("none")
  localparam int ADDR_W  = $clog2(DEPTH);

  localparam int IN_DATA_W  = 16;           // ref_id padded to whole bytes
  localparam int OUT_DATA_W = 56;           // five 11-bit fields padded

  typedef enum logic [1:0] {
    CMD_INS_LEFT  = 2'd0,
    CMD_INS_RIGHT = 2'd1,
    CMD_REMOVE    = 2'd2,
    CMD_QUERY     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EXHAUST  = 2'd1,
    ST_REF_ABS  = 2'd2,
    ST_RM_ABS   = 2'd3
  } status_t;

  localparam logic [ID_W-1:0] ID_NONE = '0;
  localparam logic [ID_W-1:0] ID_ONE  = ID_W'(1);
  localparam logic [ID_W-1:0] ID_MAX  = ID_W'(MAX_IDS);

endpackage

// File: sv/olle_ram.sv
module olle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/linked_order_list_engine.sv
// Ordered line of members kept as an array-based doubly linked list.
// Input channel (in_*): in_tuser carries the command (insert left, insert
// right, remove, query), in_tdata the reference member id. Result channel
// (out_*): out_tuser carries the status, out_tdata the assigned id, head,
// count and the reference's right and left neighbours after the command.
// One result item per input item, in order.
// Timing: the link and presence stores are RAMs with one write port and
// a registered read port. After acceptance S_RD reads the reference
// entry, an insert then passes through S_W2 for its second pair of link
// updates, and S_FIN loads the output register. The block takes one
// item at a time: in_tready is high only while idle.
// Reset (rst_n low, synchronous): the line holds member 1 alone, head 1,
// count 1, next id 2. No clearing pass: presence of an id is only trusted
// below the next free id, and entry 1 is tracked in flops.
// Stall: a result waits in the output register until out_tready; the next
// result waits in the final state, holding off further input.
module linked_order_list_engine
  import olle_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [10:0] ref_id, rest zero
  input  logic [1:0]            in_tuser,   // [1:0] cmd
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [10:0] assigned_id, [21:11] head_id,
                                            // [32:22] member_count,
                                            // [43:33] right_neighbour,
                                            // [54:44] left_neighbour, rest zero
  output logic [1:0]            out_tuser   // [1:0] status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,    // read data back: decide, first writes
    S_W2,    // second link writes of an insert
    S_FIN    // load output register
  } state_t;

  state_t           state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [ID_W-1:0]  ref_r, ref_nxt;
  logic             ref_ok_r, ref_ok_nxt;
  logic [ID_W-1:0]  head_r, head_nxt;
  logic [ID_W-1:0]  count_r, count_nxt;
  logic [ID_W-1:0]  nfree_r, nfree_nxt;
  logic             p1_r, p1_nxt;      // presence of member 1
  logic             n1v_r, n1v_nxt;    // next entry 1 written
  logic             pv1_r, pv1_nxt;    // prev entry 1 written
  logic [ID_W-1:0]  nk_r, nk_nxt;
  logic [ID_W-1:0]  pk_r, pk_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  status_t          res_st_r, res_st_nxt;
  logic [ID_W-1:0]  res_asg_r, res_asg_nxt;
  logic [ID_W-1:0]  res_rt_r, res_rt_nxt;
  logic [ID_W-1:0]  res_lt_r, res_lt_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic [OUT_DATA_W-1:0] odata_r, odata_nxt;
  status_t          ouser_r, ouser_nxt;

  // RAM ports
  logic              nx_we, pv_we, fl_we;
  logic [ADDR_W-1:0] nx_wa, pv_wa, fl_wa, rd_a;
  logic [ID_W-1:0]   nx_wd, pv_wd, nx_q, pv_q;
  logic              fl_wd, fl_q;

  logic [ID_W-1:0]   in_ref;
  logic              in_ref_ok, acc;
  logic [ID_W-1:0]   nk_c, pk_c;
  logic              present_c;

  assign in_ref    = in_tdata[ID_W-1:0];
  assign in_ref_ok = (in_ref != ID_NONE) && (in_ref <= ID_MAX);
  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign rd_a      = in_ref_ok ? ADDR_W'(in_ref) : '0;

  olle_ram #(.WIDTH(ID_W), .DEPTH(DEPTH)) u_next_ram (
    .clk, .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(rd_a), .rdata(nx_q)
  );
  olle_ram #(.WIDTH(ID_W), .DEPTH(DEPTH)) u_prev_ram (
    .clk, .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(rd_a), .rdata(pv_q)
  );
  olle_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_flag_ram (
    .clk, .we(fl_we), .waddr(fl_wa), .wdata(fl_wd), .raddr(rd_a), .rdata(fl_q)
  );

  // neighbours of the reference; entry 1 reads zero until written
  assign nk_c = (ref_r == ID_ONE && !n1v_r) ? ID_NONE : nx_q;
  assign pk_c = (ref_r == ID_ONE && !pv1_r) ? ID_NONE : pv_q;
  // ids at or above the next free id were never handed out
  assign present_c = ref_ok_r &&
                     ((ref_r == ID_ONE) ? p1_r : ((ref_r < nfree_r) && fl_q));

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    ref_nxt     = ref_r;
    ref_ok_nxt  = ref_ok_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    nfree_nxt   = nfree_r;
    p1_nxt      = p1_r;
    nk_nxt      = nk_r;
    pk_nxt      = pk_r;
    id_nxt      = id_r;
    res_st_nxt  = res_st_r;
    res_asg_nxt = res_asg_r;
    res_rt_nxt  = res_rt_r;
    res_lt_nxt  = res_lt_r;
    ovalid_nxt  = ovalid_r && !out_tready;
    odata_nxt   = odata_r;
    ouser_nxt   = ouser_r;
    nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
    pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
    fl_we = 1'b0; fl_wa = '0; fl_wd = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          cmd_nxt    = cmd_t'(in_tuser);
          ref_nxt    = in_ref;
          ref_ok_nxt = in_ref_ok;
          state_nxt  = S_RD;
        end
      end
      S_RD: begin
        res_asg_nxt = ID_NONE;
        res_rt_nxt  = ID_NONE;
        res_lt_nxt  = ID_NONE;
        res_st_nxt  = ST_OK;
        state_nxt   = S_FIN;
        nk_nxt      = nk_c;
        pk_nxt      = pk_c;
        id_nxt      = nfree_r;
        case (cmd_r)
          CMD_INS_LEFT, CMD_INS_RIGHT: begin
            if (nfree_r > ID_MAX) begin
              res_st_nxt = ST_EXHAUST;
            end else if (!present_c) begin
              res_st_nxt = ST_REF_ABS;
            end else begin
              // new entry's own links and presence
              nx_we = 1'b1; nx_wa = ADDR_W'(nfree_r);
              pv_we = 1'b1; pv_wa = ADDR_W'(nfree_r);
              fl_we = 1'b1; fl_wa = ADDR_W'(nfree_r); fl_wd = 1'b1;
              if (cmd_r == CMD_INS_LEFT) begin
                nx_wd = ref_r;
                pv_wd = pk_c;
                res_rt_nxt = nk_c;
                res_lt_nxt = nfree_r;
                if (head_r == ref_r) begin
                  head_nxt = nfree_r;
                end
              end else begin
                nx_wd = nk_c;
                pv_wd = ref_r;
                res_rt_nxt = nfree_r;
                res_lt_nxt = pk_c;
              end
              res_asg_nxt = nfree_r;
              count_nxt   = count_r + ID_ONE;
              nfree_nxt   = nfree_r + ID_ONE;
              state_nxt   = S_W2;
            end
          end
          CMD_REMOVE: begin
            if (!present_c) begin
              res_st_nxt = ST_RM_ABS;
            end else begin
              fl_we = 1'b1; fl_wa = ADDR_W'(ref_r); fl_wd = 1'b0;
              nx_we = (pk_c != ID_NONE); nx_wa = ADDR_W'(pk_c); nx_wd = nk_c;
              pv_we = (nk_c != ID_NONE); pv_wa = ADDR_W'(nk_c); pv_wd = pk_c;
              if (ref_r == ID_ONE) begin
                p1_nxt = 1'b0;
              end
              if (head_r == ref_r) begin
                head_nxt = nk_c;
              end
              count_nxt  = count_r - ID_ONE;
              res_rt_nxt = nk_c;
              res_lt_nxt = pk_c;
            end
          end
          CMD_QUERY: begin
            if (!present_c) begin
              res_st_nxt = ST_REF_ABS;
            end else begin
              res_rt_nxt = nk_c;
              res_lt_nxt = pk_c;
            end
          end
          default: begin
            res_st_nxt = ST_OK;
          end
        endcase
      end
      S_W2: begin
        // splice the new id into the reference's side
        if (cmd_r == CMD_INS_LEFT) begin
          nx_we = (pk_r != ID_NONE); nx_wa = ADDR_W'(pk_r); nx_wd = id_r;
          pv_we = 1'b1;              pv_wa = ADDR_W'(ref_r); pv_wd = id_r;
        end else begin
          pv_we = (nk_r != ID_NONE); pv_wa = ADDR_W'(nk_r); pv_wd = id_r;
          nx_we = 1'b1;              nx_wa = ADDR_W'(ref_r); nx_wd = id_r;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          ouser_nxt  = res_st_r;
          odata_nxt  = {1'b0, res_lt_r, res_rt_r, count_r, head_r, res_asg_r};
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // track first write of link entry 1
  assign n1v_nxt = n1v_r || (nx_we && nx_wa == ADDR_W'(ID_ONE));
  assign pv1_nxt = pv1_r || (pv_we && pv_wa == ADDR_W'(ID_ONE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= ID_ONE;
      count_r  <= ID_ONE;
      nfree_r  <= ID_W'(2);
      p1_r     <= 1'b1;
      n1v_r    <= 1'b0;
      pv1_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      nfree_r  <= nfree_nxt;
      p1_r     <= p1_nxt;
      n1v_r    <= n1v_nxt;
      pv1_r    <= pv1_nxt;
      ovalid_r <= ovalid_nxt;
    end
    cmd_r     <= cmd_nxt;
    ref_r     <= ref_nxt;
    ref_ok_r  <= ref_ok_nxt;
    nk_r      <= nk_nxt;
    pk_r      <= pk_nxt;
    id_r      <= id_nxt;
    res_st_r  <= res_st_nxt;
    res_asg_r <= res_asg_nxt;
    res_rt_r  <= res_rt_nxt;
    res_lt_r  <= res_lt_nxt;
    odata_r   <= odata_nxt;
    ouser_r   <= ouser_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

  // every present member was handed an id below the next free one
  a_count_below_nfree: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < nfree_r)
    else $error("member count not below next free id");

  // the line is empty exactly when there is no head
  a_head_vs_count: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == ID_NONE) == (count_r == ID_NONE))
    else $error("head and count disagree");

  // a new result is loaded only by the final state
  a_load_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovalid_r) |-> $past(state_r) == S_FIN)
    else $error("result loaded outside final state");

  // a second write cycle follows only a successful insert
  a_w2_insert: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_W2 |-> (res_st_r == ST_OK && res_asg_r != ID_NONE))
    else $error("link write cycle without insert");

endmodule
